[rtl/lifo_pkg.sv]
`timescale 1ns / 1ps

package lifo_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 2 * DATA_W;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_OUT  = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the transaction, start the top-entry read
    logic execute;  // apply the command, load the result register
  } ctrl_cmd_t;

endpackage

[rtl/lifo_ram.sv]
`timescale 1ns / 1ps

module lifo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lifo_ctrl.sv]
`timescale 1ns / 1ps

module lifo_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lifo_pkg::ctrl_cmd_t   dp_cmd
);

  lifo_pkg::state_t state;
  lifo_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lifo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lifo_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = lifo_pkg::S_EXEC;
        end
      end
      lifo_pkg::S_EXEC: begin
        state_next = lifo_pkg::S_OUT;
      end
      lifo_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = lifo_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lifo_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.execute = 1'b0;
    case (state)
      lifo_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        dp_cmd.capture = in_valid;
      end
      lifo_pkg::S_EXEC: begin
        dp_cmd.execute = 1'b1;
      end
      lifo_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/lifo_dp.sv]
`timescale 1ns / 1ps

module lifo_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  lifo_pkg::ctrl_cmd_t                 dp_cmd,
  input  logic [1:0]                          cmd,
  input  logic signed [lifo_pkg::DATA_W-1:0]  elem_x,
  input  logic signed [lifo_pkg::DATA_W-1:0]  elem_y,
  output logic signed [lifo_pkg::DATA_W-1:0]  out_x,
  output logic signed [lifo_pkg::DATA_W-1:0]  out_y,
  output logic [1:0]                          status,
  output logic [lifo_pkg::COUNT_W-1:0]        count,
  output logic                                is_empty
);

  lifo_pkg::cmd_t                    op;
  logic [lifo_pkg::DATA_W-1:0]       push_x;
  logic [lifo_pkg::DATA_W-1:0]       push_y;
  logic [lifo_pkg::FILL_W-1:0]       fill_count;
  logic [lifo_pkg::FILL_W-1:0]       fill_count_next;
  logic [lifo_pkg::FILL_W-1:0]       top_index;
  logic [lifo_pkg::ENTRY_W-1:0]      rd_entry;
  logic                              wr_en;
  logic [lifo_pkg::DATA_W-1:0]       res_x;
  logic [lifo_pkg::DATA_W-1:0]       res_y;
  lifo_pkg::status_t                 res_st;
  logic                              full;
  logic                              empty;

  assign top_index = fill_count - lifo_pkg::FILL_W'(1);
  assign full      = (fill_count >= lifo_pkg::FILL_W'(lifo_pkg::DEPTH));
  assign empty     = (fill_count == '0);

  lifo_ram #(
    .WIDTH (lifo_pkg::ENTRY_W),
    .DEPTH (lifo_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill_count[lifo_pkg::ADDR_W-1:0]),
    .wdata ({push_y, push_x}),
    .re    (dp_cmd.capture),
    .raddr (top_index[lifo_pkg::ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      op     <= lifo_pkg::cmd_t'(cmd);
      push_x <= elem_x;
      push_y <= elem_y;
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    wr_en           = 1'b0;
    res_x           = '0;
    res_y           = '0;
    res_st          = lifo_pkg::ST_DONE;
    case (op)
      lifo_pkg::CMD_PUSH: begin
        if (full) begin
          res_st = lifo_pkg::ST_FULL;
        end else begin
          wr_en           = dp_cmd.execute;
          fill_count_next = fill_count + lifo_pkg::FILL_W'(1);
        end
      end
      lifo_pkg::CMD_POP, lifo_pkg::CMD_PEEK: begin
        if (empty) begin
          res_st = lifo_pkg::ST_EMPTY;
        end else begin
          res_x = rd_entry[lifo_pkg::DATA_W-1:0];
          res_y = rd_entry[lifo_pkg::ENTRY_W-1:lifo_pkg::DATA_W];
          if (op == lifo_pkg::CMD_POP) begin
            fill_count_next = top_index;
          end
        end
      end
      lifo_pkg::CMD_CLEAR: begin
        fill_count_next = '0;
      end
      default: begin
        fill_count_next = fill_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (dp_cmd.execute) begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      out_x    <= res_x;
      out_y    <= res_y;
      status   <= res_st;
      count    <= lifo_pkg::COUNT_W'(fill_count_next);
      is_empty <= (fill_count_next == '0);
    end
  end

endmodule

[rtl/lifo_stack.sv]
`timescale 1ns / 1ps
// out_valid rises when the controller reaches S_OUT, after S_EXEC, following the
// edge that accepts the input transaction; it stays high until out_ready.
// Transactions do not overlap: a new one is accepted only after the registered
// read of the entry RAM and the result register handshake of the one before.
// Reset (synchronous, active high) empties the stack and the controller;
// the entry RAM is not cleared, since only entries below the fill level are used.

module lifo_stack (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          cmd,
  input  logic signed [lifo_pkg::DATA_W-1:0]  elem_x,
  input  logic signed [lifo_pkg::DATA_W-1:0]  elem_y,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lifo_pkg::DATA_W-1:0]  out_x,
  output logic signed [lifo_pkg::DATA_W-1:0]  out_y,
  output logic [1:0]                          status,
  output logic [lifo_pkg::COUNT_W-1:0]        count,
  output logic                                is_empty
);

  // Commands from the controller: capture the accepted transaction and start
  // the top-entry read, then execute it in the following cycle, when read data lands.
  lifo_pkg::ctrl_cmd_t dp_cmd;

  lifo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  // Datapath: fill counter, entry RAM and the result register. The result
  // register holds its transaction until the downstream side takes it.
  lifo_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .dp_cmd   (dp_cmd),
    .cmd      (cmd),
    .elem_x   (elem_x),
    .elem_y   (elem_y),
    .out_x    (out_x),
    .out_y    (out_y),
    .status   (status),
    .count    (count),
    .is_empty (is_empty)
  );

  // Only one transaction is in flight: never accept while a result is shown.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  // The empty flag agrees with the reported count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  // A rejected push is only reported when the stack really holds DEPTH entries.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == lifo_pkg::ST_FULL)) |->
      (count == lifo_pkg::COUNT_W'(lifo_pkg::DEPTH)))
    else $error("full status with a partial stack");

  // Error results carry a zero pair.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != lifo_pkg::ST_DONE)) |-> ((out_x == '0) && (out_y == '0)))
    else $error("error result with a nonzero pair");

  // An accepted transaction yields a result once the controller passes S_EXEC into S_OUT.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result not delivered on schedule");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  // One command as the sender holds it; hold_for_drain makes the driver wait
  // until every earlier transaction has produced its result.
  typedef struct {
    lifo_pkg::cmd_t op;
    logic [31:0]    x;
    logic [31:0]    y;
    bit             hold_for_drain;
  } stack_req_t;

  typedef struct {
    logic [31:0]                  rx;
    logic [31:0]                  ry;
    lifo_pkg::status_t            st;
    logic [lifo_pkg::COUNT_W-1:0] cnt;
    logic                         emp;
  } stack_resp_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   cmd = lifo_pkg::CMD_PUSH;
  logic signed [31:0]           elem_x = '0;
  logic signed [31:0]           elem_y = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [31:0]           out_x;
  logic signed [31:0]           out_y;
  logic [1:0]                   status;
  logic [lifo_pkg::COUNT_W-1:0] count;
  logic                         is_empty;

  lifo_stack i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .elem_x    (elem_x),
    .elem_y    (elem_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
  );

  // Commands waiting to be sent and results waiting to arrive.
  stack_req_t  pending_cmds[$];
  stack_resp_t expected_results[$];

  // Shadow copy of the stack.
  int          shadow_fill = 0;
  logic [63:0] shadow_entries [lifo_pkg::DEPTH];

  // Fill level as the generator sees it, to shape sequences.
  int gen_fill = 0;
  bit drain_next = 1'b0;

  int n_total = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_full_refused = 0;
  int n_empty_refused = 0;
  int n_clears = 0;
  int peak_fill = 0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  bit offer;
  stack_resp_t want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one command to the shadow stack and return the result it must give.
  function automatic stack_resp_t stack_predict(lifo_pkg::cmd_t op, logic [31:0] x,
                                                logic [31:0] y);
    stack_resp_t r;
    r.rx = '0;
    r.ry = '0;
    r.st = lifo_pkg::ST_DONE;
    case (op)
      lifo_pkg::CMD_PUSH: begin
        if (shadow_fill >= lifo_pkg::DEPTH) begin
          r.st = lifo_pkg::ST_FULL;
          n_full_refused++;
        end else begin
          shadow_entries[shadow_fill] = {y, x};
          shadow_fill++;
        end
      end
      lifo_pkg::CMD_POP, lifo_pkg::CMD_PEEK: begin
        if (shadow_fill == 0) begin
          r.st = lifo_pkg::ST_EMPTY;
          n_empty_refused++;
        end else begin
          {r.ry, r.rx} = shadow_entries[shadow_fill - 1];
          if (op == lifo_pkg::CMD_POP) shadow_fill--;
        end
      end
      default: begin
        shadow_fill = 0;
        n_clears++;
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.cnt = shadow_fill[lifo_pkg::COUNT_W-1:0];
    r.emp = (shadow_fill == 0);
    return r;
  endfunction

  // Mostly random words, with the corner values mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic lifo_pkg::cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return lifo_pkg::CMD_PUSH;
    if (r < 75) return lifo_pkg::CMD_POP;
    if (r < 95) return lifo_pkg::CMD_PEEK;
    return lifo_pkg::CMD_CLEAR;
  endfunction

  task automatic queue_cmd(lifo_pkg::cmd_t op, logic [31:0] x, logic [31:0] y);
    stack_req_t it;
    it.op = op;
    it.x = x;
    it.y = y;
    it.hold_for_drain = drain_next;
    drain_next = 1'b0;
    pending_cmds.push_back(it);
    n_total++;
    case (op)
      lifo_pkg::CMD_PUSH:  if (gen_fill < lifo_pkg::DEPTH) gen_fill++;
      lifo_pkg::CMD_POP:   if (gen_fill > 0) gen_fill--;
      lifo_pkg::CMD_CLEAR: gen_fill = 0;
      default:   ;
    endcase
  endtask

  // Element fields are random on every command; the stack must ignore them
  // on anything but a push.
  task automatic queue_rand(lifo_pkg::cmd_t op);
    queue_cmd(op, rand_word(), rand_word());
  endtask

  task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
    end
  endtask

  // Driver: send pending commands in bursts separated by random gaps. Hold
  // the payload while a transaction is offered and not yet taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_cmds.delete(0);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold_for_drain && n_checked != n_sent)) begin
          offer = 1'b1;
          cmd <= pending_cmds[0].op;
          elem_x <= pending_cmds[0].x;
          elem_y <= pending_cmds[0].y;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            // long run with no idling
            burst_left = $urandom_range(40, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver: stall on a pattern that changes mode at random intervals.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 4);
        stall_left = $urandom_range(8, 60);
      end
      stall_left--;
      case (stall_mode)
        0, 1:    out_ready <= 1'b1;
        2:       out_ready <= $urandom_range(0, 1);
        3:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  // Monitor: predict on every accepted command, check every accepted result
  // against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(stack_predict(lifo_pkg::cmd_t'(cmd), elem_x, elem_y));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t ns: unexpected result, expected none, actual x=%h y=%h st=%0d cnt=%0d",
                   $time, out_x, out_y, status, count);
        end else begin
          want = expected_results.pop_front();
          check_field("out_x", want.rx, out_x);
          check_field("out_y", want.ry, out_y);
          check_field("status", 32'(want.st), 32'(status));
          check_field("count", 32'(want.cnt), 32'(count));
          check_field("is_empty", 32'(want.emp), 32'(is_empty));
          n_checked++;
        end
      end
    end
  end

  initial begin
    int next_drain_at;
    int random_end;
    // Directed: underflow on a fresh stack, extreme pairs, LIFO order,
    // clears on empty and non-empty stacks.
    queue_rand(lifo_pkg::CMD_POP);
    queue_rand(lifo_pkg::CMD_PEEK);
    queue_rand(lifo_pkg::CMD_CLEAR);
    queue_cmd(lifo_pkg::CMD_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_cmd(lifo_pkg::CMD_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_cmd(lifo_pkg::CMD_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_cmd(lifo_pkg::CMD_PUSH, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_cmd(lifo_pkg::CMD_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(lifo_pkg::CMD_POP, 32'h1234_5678, 32'h9ABC_DEF0);
    queue_rand(lifo_pkg::CMD_PEEK);
    queue_rand(lifo_pkg::CMD_POP);
    queue_rand(lifo_pkg::CMD_POP);
    queue_rand(lifo_pkg::CMD_POP);
    queue_rand(lifo_pkg::CMD_POP);
    queue_rand(lifo_pkg::CMD_PEEK);
    queue_cmd(lifo_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_rand(lifo_pkg::CMD_CLEAR);
    queue_rand(lifo_pkg::CMD_PEEK);

    // Random: mostly fill-to-overflow and drain-to-underflow sequences,
    // plus random walks, clears and noise. Pause for a full drain now and then.
    next_drain_at = n_total;
    random_end = n_total + 900;
    while (n_total < random_end) begin
      if (n_total >= next_drain_at) begin
        drain_next = 1'b1;
        next_drain_at += 300;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          while (gen_fill < lifo_pkg::DEPTH) begin
            if ($urandom_range(0, 9) == 0) queue_rand(lifo_pkg::CMD_PEEK);
            queue_rand(lifo_pkg::CMD_PUSH);
          end
          repeat ($urandom_range(1, 3)) queue_rand(lifo_pkg::CMD_PUSH);
          queue_rand(lifo_pkg::CMD_PEEK);
        end
        2, 3: begin
          while (gen_fill > 0) begin
            if ($urandom_range(0, 9) == 0) queue_rand(lifo_pkg::CMD_PEEK);
            queue_rand(lifo_pkg::CMD_POP);
          end
          repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 1) != 0) queue_rand(lifo_pkg::CMD_POP);
            else queue_rand(lifo_pkg::CMD_PEEK);
          end
        end
        4, 5, 6: repeat ($urandom_range(10, 40)) queue_rand(pick_cmd());
        7: repeat ($urandom_range(5, 15)) queue_rand(lifo_pkg::cmd_t'($urandom_range(0, 3)));
        8: begin
          queue_rand(lifo_pkg::CMD_CLEAR);
          repeat ($urandom_range(1, 6)) queue_rand(lifo_pkg::CMD_PUSH);
          queue_rand(lifo_pkg::CMD_PEEK);
          queue_rand(lifo_pkg::CMD_POP);
        end
        default: begin
          repeat ($urandom_range(2, 10)) begin
            queue_rand(lifo_pkg::CMD_PUSH);
            queue_rand(lifo_pkg::CMD_POP);
          end
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every result, then keep the clock running to catch strays.
    wait (n_checked == n_total);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      n_errors++;
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, expected_results.size());
    end

    $display("Checked %0d results; %0d pushes refused when full,", n_checked, n_full_refused);
    $display("%0d pops/peeks refused when empty, deepest fill %0d of %0d entries, %0d clears",
             n_empty_refused, peak_fill, lifo_pkg::DEPTH, n_clears);
    if (n_errors == 0) begin
      $display("PASS lifo_stack");
    end else begin
      $display("FAIL lifo_stack");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL lifo_stack");
    $finish;
  end

endmodule
